### rtl/core/fbm_pkg.sv
package fbm_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = FRAME_W - BIT_W;
  localparam int CFG_W      = FRAME_W + 1;
  localparam int CNT_W      = CFG_W - BIT_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0]     FRAME_COUNT_RST = CFG_W'(MAX_FRAMES);
  localparam logic [WORD_BITS-1:0] FULL_WORD       = '1;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_NOP   = 2'd1,
    ST_OOF   = 2'd2,
    ST_FREED = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_FREE_RD  = 6'b000010,
    S_FREE_WR  = 6'b000100,
    S_SCAN     = 6'b001000,
    S_ALLOC_WR = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    rd_free;
    logic    scan_rd;
    logic    wr_free;
    logic    wr_alloc;
    logic    out_load;
    status_t out_status;
  } fbm_cmd_t;

  typedef struct packed {
    logic in_free;
    logic in_cur_zero;
    logic hit;
    logic more;
  } fbm_sts_t;

endpackage

### rtl/core/frame_bitmap_allocator.sv
// First-fit allocator of physical page frames over a bitmap of 4096 frames.
// Requests arrive on the s_ channel: s_tuser is the request kind (allocate or
// free) and s_tdata carries the page's current frame and the entry flags.
// Each request yields exactly one result item on the m_ channel: m_tdata holds
// the frame and entry bits, m_tuser the outcome code.
// A request that needs no bitmap access (page already holds a frame, or a free
// of frame zero) goes straight to its response; a free reads its bitmap word,
// writes it back and then responds. An allocation reads one bitmap word per
// cycle starting at word 0 until it finds a word with a clear bit, through
// at most all 128 words, then writes that word back and responds.
// One request is in flight at a time; the next is accepted once the previous
// one has been handed to the result register.
// Reset clears every frame to free at once (per-word valid flags, no clearing
// pass) and sets frame_count to 4096. The result register holds a finished
// item while m_tready is low, and the block may accept and work on the next
// request meanwhile; it then waits in its response state until that register
// is free. frame_count is written through cfg_wr_en and cfg_wr_data.
module frame_bitmap_allocator
  import fbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: current_frame[11:0], is_kernel[12], want_writable[13], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: mode (0 allocate, 1 free)
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: frame_out[11:0], present[12], writable[13], user[14], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: status (0 allocated, 1 nothing done, 2 out of frames, 3 freed)
  output logic [1:0]            m_tuser
);

  fbm_cmd_t cmd;
  fbm_sts_t sts;

  fbm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fbm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (s_tdata),
    .in_mode     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (m_tdata),
    .out_status  (m_tuser)
  );

  // A bitmap write is never the last step of a request: a response follows.
  a_write_then_busy : assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_alloc || cmd.wr_free) |=> !s_tready)
    else $error("request slot freed right after a bitmap write");

  // Entry bits are only set on a successful allocation.
  a_bits_only_alloc : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_ALLOC)) |-> (m_tdata[14:12] == 3'b000))
    else $error("entry bits set on a result that allocated nothing");

  // Frees and failed allocations report frame zero.
  a_zero_frame : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser == ST_FREED) || (m_tuser == ST_OOF)))
      |-> (m_tdata[11:0] == '0))
    else $error("nonzero frame on a free or out-of-frames result");

  // An allocation always marks the entry present.
  a_alloc_present : assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && (cmd.out_status == ST_ALLOC)) |=> m_tdata[12])
    else $error("allocated result without the present bit");

endmodule

### rtl/core/fbm_ctrl.sv
module fbm_ctrl
  import fbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  output logic     s_ready,
  output logic     m_valid,
  input  logic     m_ready,
  input  fbm_sts_t sts,
  output fbm_cmd_t cmd
);

  state_t  state, state_next;
  status_t stat, stat_next;
  logic    out_valid;

  always_comb begin
    state_next = state;
    stat_next  = stat;
    cmd        = '0;
    cmd.out_status = stat;
    s_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_ready     = 1'b1;
        cmd.capture = s_valid;
        if (s_valid) begin
          if (sts.in_free) begin
            if (sts.in_cur_zero) begin
              stat_next  = ST_NOP;
              state_next = S_RESP;
            end else begin
              state_next = S_FREE_RD;
            end
          end else if (!sts.in_cur_zero) begin
            stat_next  = ST_NOP;
            state_next = S_RESP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_FREE_RD: begin
        cmd.rd_free = 1'b1;
        state_next  = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.wr_free = 1'b1;
        stat_next   = ST_FREED;
        state_next  = S_RESP;
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_next = S_ALLOC_WR;
        end else if (sts.more) begin
          cmd.scan_rd = 1'b1;
        end else begin
          stat_next  = ST_OOF;
          state_next = S_RESP;
        end
      end
      S_ALLOC_WR: begin
        cmd.wr_alloc = 1'b1;
        stat_next    = ST_ALLOC;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || m_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stat      <= ST_NOP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      stat  <= stat_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_valid = out_valid;

endmodule

### rtl/core/fbm_datapath.sv
module fbm_datapath
  import fbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_mode,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  fbm_cmd_t              cmd,
  output fbm_sts_t              sts,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [1:0]            out_status
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_valid;

  logic [CFG_W-1:0]   frame_count;
  logic [FRAME_W-1:0] cur;
  logic               kern;
  logic               want_wr;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   widx;

  logic [WORD_BITS-1:0] word_q;
  logic                 word_q_valid;
  logic [WADDR_W-1:0]   chk_idx;
  logic                 chk_valid;
  logic [FRAME_W-1:0]   found;

  logic [WORD_BITS-1:0] word_eff;
  logic [BIT_W-1:0]     first_zero;
  logic [BIT_W-1:0]     wr_bit;
  logic [WORD_BITS-1:0] wr_mask;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic [CNT_W-1:0]     words_cfg;

  logic [FRAME_W-1:0] out_frame;
  logic               out_present;
  logic               out_writable;
  logic               out_user;

  // An entry never written since reset reads as an all-free word.
  assign word_eff = word_q_valid ? word_q : '0;

  // Lowest clear bit of the word under check.
  always_comb begin
    first_zero = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!word_eff[j]) begin
        first_zero = BIT_W'(j);
      end
    end
  end

  assign words_cfg = frame_count[CFG_W-1:BIT_W];
  assign rd_en     = cmd.rd_free | cmd.scan_rd;
  assign rd_addr   = cmd.rd_free ? cur[FRAME_W-1:BIT_W] : widx[WADDR_W-1:0];
  assign wr_en     = cmd.wr_free | cmd.wr_alloc;
  assign wr_bit    = cmd.wr_alloc ? first_zero : cur[BIT_W-1:0];
  assign wr_mask   = WORD_BITS'(1) << wr_bit;
  assign wr_data   = cmd.wr_alloc ? (word_eff | wr_mask) : (word_eff & ~wr_mask);

  assign sts.in_free     = in_mode;
  assign sts.in_cur_zero = (in_data[FRAME_W-1:0] == '0);
  assign sts.hit         = chk_valid && (word_eff != FULL_WORD);
  assign sts.more        = (widx < lim);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[chk_idx] <= wr_data;
    end
    if (rd_en) begin
      word_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid   <= '0;
      frame_count  <= FRAME_COUNT_RST;
      chk_valid    <= 1'b0;
      widx         <= '0;
      lim          <= '0;
      word_q_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_count <= cfg_wr_data;
      end
      if (wr_en) begin
        word_valid[chk_idx] <= 1'b1;
      end
      if (cmd.capture) begin
        widx      <= '0;
        chk_valid <= 1'b0;
        lim       <= (words_cfg > CNT_W'(NUM_WORDS)) ? CNT_W'(NUM_WORDS) : words_cfg;
      end else begin
        if (cmd.scan_rd) begin
          widx <= widx + 1'b1;
        end
        chk_valid <= cmd.scan_rd;
      end
      if (rd_en) begin
        word_q_valid <= word_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur     <= in_data[FRAME_W-1:0];
      kern    <= in_data[FRAME_W];
      want_wr <= in_data[FRAME_W+1];
    end
    if (rd_en) begin
      chk_idx <= rd_addr;
    end
    if (cmd.wr_alloc) begin
      found <= {chk_idx, first_zero};
    end
  end

  // Result register: the payload is formed from the outcome code.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status   <= cmd.out_status;
      out_present  <= 1'b0;
      out_writable <= 1'b0;
      out_user     <= 1'b0;
      unique case (cmd.out_status)
        ST_ALLOC: begin
          out_frame    <= found;
          out_present  <= 1'b1;
          out_writable <= want_wr;
          out_user     <= ~kern;
        end
        ST_NOP:   out_frame <= cur;
        ST_OOF:   out_frame <= '0;
        ST_FREED: out_frame <= '0;
        default:  out_frame <= '0;
      endcase
    end
  end

  assign out_data = OUT_DATA_W'({out_user, out_writable, out_present, out_frame});

endmodule

### dv/frame_bitmap_allocator_tb.sv
`timescale 1ns / 1ps

module frame_bitmap_allocator_tb
  import fbm_pkg::*;
;

  // The slowest legal run is well below this: every allocation scans at most
  // 128 words, and stalls on either side are short apart from one long hold.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Bounded prefetch of requests, so that frees can pick frames that the
  // frame map has actually handed out a few items earlier.
  localparam int unsigned PREFETCH = 4;
  // The long receiver hold-off starts once this many results have been seen.
  localparam int unsigned HOLD_AFTER = 400;
  localparam int unsigned HOLD_CYCLES = 400;
  // Longest allocation scan plus response, used for the drain at the end.
  localparam int unsigned DRAIN_CYCLES = 140;

  // One page request as it travels on the s_ channel.
  typedef struct {
    logic              release_req;   // mode: 0 allocate, 1 free
    logic [FRAME_W-1:0] cur_frame;
    logic              kernel;
    logic              writable;
  } page_req_t;

  // The page-entry update the block must report for one request.
  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
    status_t            status;
  } entry_update_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata: current_frame[11:0], is_kernel[12], want_writable[13], zero fill
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // s_tuser: mode (0 allocate, 1 free)
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata: frame_out[11:0], present[12], writable[13], user[14], zero fill
  logic [OUT_DATA_W-1:0] m_tdata;
  // m_tuser: status (0 allocated, 1 nothing done, 2 out of frames, 3 freed)
  logic [1:0]            m_tuser;

  frame_bitmap_allocator u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: its frame map and its frame_count register.
  logic [WORD_BITS-1:0] frame_map [NUM_WORDS];
  logic [CFG_W-1:0]     map_frames = FRAME_COUNT_RST;

  page_req_t            pending_reqs[$];
  entry_update_t        expected_updates[$];
  // Frames that the shadow map handed out; the stimulus frees from this list.
  logic [FRAME_W-1:0]   held_frames[$];

  page_req_t   next_req;
  bit          item_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          pressure_done = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int w = 0; w < NUM_WORDS; w++) frame_map[w[WADDR_W-1:0]] = '0;
  end

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long gap. Quiet stretches have no idling at all.
  function automatic int unsigned idle_cycles(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // First-fit allocate or free on the shadow map; returns the entry update.
  function automatic entry_update_t apply_page_request(page_req_t req);
    entry_update_t upd;
    int unsigned   words;
    int unsigned   w;
    int unsigned   b;
    int unsigned   pick;
    bit            found;
    upd = '{frame: '0, present: 1'b0, writable: 1'b0, user: 1'b0, status: ST_NOP};
    found = 1'b0;
    pick = 0;
    if (!req.release_req) begin
      if (req.cur_frame != '0) begin
        // The page already has a frame: echo it back, touch nothing.
        upd.frame = req.cur_frame;
      end else begin
        // Only whole 32-frame words below frame_count are searched, and
        // never more words than the map holds.
        words = map_frames / WORD_BITS;
        if (words > NUM_WORDS) words = NUM_WORDS;
        for (w = 0; w < words && !found; w++) begin
          if (frame_map[w[WADDR_W-1:0]] != FULL_WORD) begin
            for (b = 0; b < WORD_BITS && !found; b++) begin
              if (!frame_map[w[WADDR_W-1:0]][b[BIT_W-1:0]]) begin
                found = 1'b1;
                pick = w * WORD_BITS + b;
              end
            end
          end
        end
        if (found) begin
          frame_map[pick[FRAME_W-1:BIT_W]][pick[BIT_W-1:0]] = 1'b1;
          upd.frame    = pick[FRAME_W-1:0];
          upd.present  = 1'b1;
          upd.writable = req.writable;
          upd.user     = ~req.kernel;
          upd.status   = ST_ALLOC;
          held_frames.push_back(pick[FRAME_W-1:0]);
        end else begin
          upd.status = ST_OOF;
        end
      end
    end else if (req.cur_frame != '0) begin
      // A free clears the bit even above frame_count; frame zero is "none".
      frame_map[req.cur_frame[FRAME_W-1:BIT_W]][req.cur_frame[BIT_W-1:0]] = 1'b0;
      upd.status = ST_FREED;
    end
    return upd;
  endfunction

  // Request driver: takes items from the pending queue, inserts random gaps
  // and holds an item steady until the block accepts it.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !item_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        s_tdata  <= IN_DATA_W'({next_req.writable, next_req.kernel, next_req.cur_frame});
        s_tuser  <= next_req.release_req;
        s_tvalid <= 1'b1;
        items_sent++;
        send_gap = idle_cycles((items_sent / 150) % 4 == 2);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, quiet stretches, and one long hold-off
  // while requests keep coming, so the block fills up and stalls its input.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!pressure_done && results_seen >= HOLD_AFTER && s_tvalid) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left = idle_cycles((results_seen / 150) % 4 == 1);
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted
  // result against the oldest prediction.
  always @(posedge clk) begin
    page_req_t     seen_req;
    entry_update_t want;
    entry_update_t got;
    item_taken = s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.frame    = m_tdata[FRAME_W-1:0];
        got.present  = m_tdata[FRAME_W];
        got.writable = m_tdata[FRAME_W+1];
        got.user     = m_tdata[FRAME_W+2];
        got.status   = status_t'(m_tuser);
        if (expected_updates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result frame=%0d status=%0d arrived with nothing expected",
                     $time, got.frame, got.status);
        end else begin
          want = expected_updates.pop_front();
          if (got.frame != want.frame || got.present != want.present ||
              got.writable != want.writable || got.user != want.user ||
              got.status != want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected frame=%0d p=%b w=%b u=%b status=%0d", $time,
                       want.frame, want.present, want.writable, want.user, want.status);
              $display("%0t: got      frame=%0d p=%b w=%b u=%b status=%0d", $time,
                       got.frame, got.present, got.writable, got.user, got.status);
            end
          end
        end
      end
      if (item_taken) begin
        seen_req.release_req = s_tuser;
        seen_req.cur_frame   = s_tdata[FRAME_W-1:0];
        seen_req.kernel      = s_tdata[FRAME_W];
        seen_req.writable    = s_tdata[FRAME_W+1];
        expected_updates.push_back(apply_page_request(seen_req));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Queues one request, keeping only a few ahead of the driver.
  task automatic send_request(logic release_req, logic [FRAME_W-1:0] cur_frame,
                              logic kernel, logic writable);
    page_req_t req;
    req = '{release_req: release_req, cur_frame: cur_frame, kernel: kernel,
            writable: writable};
    while (pending_reqs.size() >= PREFETCH) @(posedge clk);
    pending_reqs.push_back(req);
  endtask

  // Waits until nothing is queued, offered or outstanding. Every item that
  // the driver took from the queue must have come back as a result.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || results_seen < items_sent)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // frame_count is only rewritten while the block is idle.
  task automatic set_frame_count(logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    map_frames = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A phase of random traffic. Most requests are allocations of empty pages
  // and frees of frames really held, so the map fills and drains; the rest
  // are allocations for pages that already hold a frame and frees of
  // arbitrary frames, frame zero among them.
  task automatic random_phase(int unsigned count, int unsigned alloc_pct);
    int unsigned r;
    int unsigned idx;
    logic [FRAME_W-1:0] victim;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        send_request(1'b0, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (r < alloc_pct + 20 && held_frames.size() != 0) begin
        idx = $urandom_range(0, held_frames.size() - 1);
        victim = held_frames[idx];
        held_frames.delete(idx);
        send_request(1'b1, victim, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (r < alloc_pct + 25) begin
        send_request(1'b0, FRAME_W'($urandom_range(1, 4095)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        victim = ($urandom_range(0, 7) == 0) ? '0 : FRAME_W'($urandom_range(1, 4095));
        send_request(1'b1, victim, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed part, starting from the reset frame_count of 4096.
    // Frame zero is a real frame to the scan and goes out first.
    send_request(1'b0, 12'd0, 1'b0, 1'b1);
    send_request(1'b0, 12'd0, 1'b1, 1'b0);
    send_request(1'b0, 12'd0, 1'b1, 1'b1);
    // Pages that already hold a frame are left alone.
    send_request(1'b0, 12'hFFF, 1'b0, 1'b0);
    send_request(1'b0, 12'hAAA, 1'b1, 1'b1);
    // Freeing frame zero does nothing; freeing a frame reuses it next.
    send_request(1'b1, 12'd0, 1'b0, 1'b0);
    send_request(1'b1, 12'd1, 1'b1, 1'b1);
    send_request(1'b0, 12'd0, 1'b0, 1'b0);
    // Frees of frames that were never handed out still report freed.
    send_request(1'b1, 12'hFFF, 1'b0, 1'b0);
    send_request(1'b1, 12'h555, 1'b1, 1'b0);
    send_request(1'b1, 12'hAAA, 1'b0, 1'b1);

    // No whole word to scan: every allocation runs out of frames, while a
    // free above frame_count still clears its bit.
    set_frame_count(13'd0);
    send_request(1'b0, 12'd0, 1'b0, 1'b0);
    send_request(1'b1, 12'd2, 1'b0, 1'b0);
    send_request(1'b0, 12'd0, 1'b1, 1'b1);

    // The largest frame_count: the scan stops at the words the map holds.
    set_frame_count(13'h1FFF);
    send_request(1'b0, 12'd0, 1'b0, 1'b0);
    send_request(1'b0, 12'd0, 1'b0, 1'b1);
    send_request(1'b1, 12'd3, 1'b1, 1'b1);

    // Random phases over several frame_count settings. The map is kept
    // across settings, so small counts soon run out of frames.
    set_frame_count(13'd32);
    random_phase(120, 75);
    set_frame_count(13'd64);
    random_phase(120, 75);
    set_frame_count(13'h1FFF);
    random_phase(120, 60);
    set_frame_count(13'd0);
    random_phase(100, 50);
    set_frame_count(13'd96);
    random_phase(120, 70);
    set_frame_count(13'd4096);
    random_phase(120, 55);
    set_frame_count(13'd4095);
    random_phase(120, 45);
    set_frame_count(13'd160);
    random_phase(120, 75);
    set_frame_count(13'd33);
    random_phase(120, 70);
    set_frame_count(13'd31);
    random_phase(100, 50);

    // Drain, then give a stray result time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_updates.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
